>>> hdl/input_step_sequence_queue_defines.svh
// assertion macros used by the isq_ctrl design file
`ifndef INPUT_STEP_SEQUENCE_QUEUE_DEFINES_SVH
`define INPUT_STEP_SEQUENCE_QUEUE_DEFINES_SVH

// same-cycle implication
`define ISQ_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ISQ_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/isq_pkg.sv
package isq_pkg;

  localparam int QUEUE_DEPTH_DEF = 32;
  localparam int MAX_RESULTS     = 32;

  localparam int OP_W    = 2;
  localparam int SEQ_W   = 32;
  localparam int DATA_W  = 64;
  localparam int DT_W    = 20;
  localparam int ACC_W   = 32;
  localparam int DRAIN_W = 6;
  localparam int IDLE_W  = 24;
  localparam int MEM_W   = SEQ_W + DATA_W;
  localparam int APB_AW  = 3;
  localparam int APB_DW  = 32;

  localparam logic [DRAIN_W-1:0] DRAIN_RST = DRAIN_W'(4);
  localparam logic [IDLE_W-1:0]  IDLE_RST  = IDLE_W'(250000);

  localparam logic REG_DRAIN = 1'b0;
  localparam logic REG_IDLE  = 1'b1;

  typedef enum logic [OP_W-1:0] {
    OP_STEP  = 2'd0,
    OP_TICK  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_RSVD  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_EMIT,
    S_IDLE_STEP
  } state_t;

endpackage

>>> hdl/input_step_sequence_queue.sv
// Jitter buffer for numbered input steps of one sender.
// Input channel (in_valid/in_ready): one beat is an opcode with its fields:
//   step arrival (queued unless its number is below the expected one),
//   tick (drains up to drain_limit queued steps, clamped to 1..32, or may
//   give one idle step), queue clear. Unused opcode is ignored.
// Result channel (out_valid/out_ready): one beat per applied step or idle
//   step, out_last marks the final beat of a tick.
// Configuration: APB write/read of drain_limit (0x0) and idle_after_us (0x4),
//   pready tied high; user writes only while the block is quiet (unchecked).
// Sequence: an arrival or clear passes through S_EXEC; a tick passes through
//   S_EXEC and then, per drained step, S_READ and S_EMIT (S_IDLE_STEP when
//   it gives an idle step); S_READ is the registered read of the queue memory
//   before each beat, and S_EMIT or S_IDLE_STEP loads the result register.
// One item is processed at a time; in_ready is low until it is finished.
// The result register frees the core as soon as the last beat is loaded.
// If the receiver stalls, the drain holds with the next step read and waits.
// Reset (rst_n, synchronous) empties the queue, clears the expected and last
//   applied numbers and the idle time, and restores the register defaults.
//   Queue memory contents are not cleared; no clearing pass is needed.
module input_step_sequence_queue #(
  parameter int QUEUE_DEPTH = isq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [isq_pkg::OP_W-1:0]      in_opcode,
  input  logic [isq_pkg::SEQ_W-1:0]     in_step_seq,
  input  logic [isq_pkg::DATA_W-1:0]    in_step_data,
  input  logic [isq_pkg::DT_W-1:0]      in_tick_dt_us,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [isq_pkg::SEQ_W-1:0]     out_seq_number,
  output logic [isq_pkg::DATA_W-1:0]    out_payload_out,
  output logic                          out_idle_step,
  output logic [isq_pkg::DT_W-1:0]      out_idle_dt_us,
  output logic                          out_last,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [isq_pkg::APB_AW-1:0]    cfg_paddr,
  input  logic [isq_pkg::APB_DW-1:0]    cfg_pwdata,
  output logic [isq_pkg::APB_DW-1:0]    cfg_prdata,
  output logic                          cfg_pready
);
  import isq_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);

  logic [DRAIN_W-1:0] drain_limit_r;
  logic [IDLE_W-1:0]  idle_after_r;
  logic               cfg_wr;

  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [MEM_W-1:0]   mem_wdata;
  logic               mem_re;
  logic [AW-1:0]      mem_raddr;
  logic [MEM_W-1:0]   mem_rdata;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drain_limit_r <= DRAIN_RST;
      idle_after_r  <= IDLE_RST;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        REG_DRAIN: drain_limit_r <= cfg_pwdata[DRAIN_W-1:0];
        REG_IDLE:  idle_after_r  <= cfg_pwdata[IDLE_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_DRAIN: cfg_prdata = APB_DW'(drain_limit_r);
      REG_IDLE:  cfg_prdata = APB_DW'(idle_after_r);
    endcase
  end

  isq_ctrl #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_opcode       (in_opcode),
    .in_step_seq     (in_step_seq),
    .in_step_data    (in_step_data),
    .in_tick_dt_us   (in_tick_dt_us),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_seq_number  (out_seq_number),
    .out_payload_out (out_payload_out),
    .out_idle_step   (out_idle_step),
    .out_idle_dt_us  (out_idle_dt_us),
    .out_last        (out_last),
    .drain_limit     (drain_limit_r),
    .idle_after_us   (idle_after_r),
    .mem_we          (mem_we),
    .mem_waddr       (mem_waddr),
    .mem_wdata       (mem_wdata),
    .mem_re          (mem_re),
    .mem_raddr       (mem_raddr),
    .mem_rdata       (mem_rdata)
  );

  isq_mem #(
    .DEPTH(QUEUE_DEPTH),
    .WIDTH(MEM_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

>>> hdl/isq_mem.sv
module isq_mem #(
  parameter int DEPTH = isq_pkg::QUEUE_DEPTH_DEF,
  parameter int WIDTH = isq_pkg::MEM_W
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/isq_ctrl.sv
`include "input_step_sequence_queue_defines.svh"

module isq_ctrl #(
  parameter int QUEUE_DEPTH = isq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [isq_pkg::OP_W-1:0]         in_opcode,
  input  logic [isq_pkg::SEQ_W-1:0]        in_step_seq,
  input  logic [isq_pkg::DATA_W-1:0]       in_step_data,
  input  logic [isq_pkg::DT_W-1:0]         in_tick_dt_us,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [isq_pkg::SEQ_W-1:0]        out_seq_number,
  output logic [isq_pkg::DATA_W-1:0]       out_payload_out,
  output logic                             out_idle_step,
  output logic [isq_pkg::DT_W-1:0]         out_idle_dt_us,
  output logic                             out_last,
  input  logic [isq_pkg::DRAIN_W-1:0]      drain_limit,
  input  logic [isq_pkg::IDLE_W-1:0]       idle_after_us,
  output logic                             mem_we,
  output logic [$clog2(QUEUE_DEPTH)-1:0]   mem_waddr,
  output logic [isq_pkg::MEM_W-1:0]        mem_wdata,
  output logic                             mem_re,
  output logic [$clog2(QUEUE_DEPTH)-1:0]   mem_raddr,
  input  logic [isq_pkg::MEM_W-1:0]        mem_rdata
);
  import isq_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int RW = $clog2(MAX_RESULTS + 1);
  localparam int TW = (CW > RW) ? CW : RW;

  state_t              state_r, state_nxt;
  op_t                 op_r;
  logic [SEQ_W-1:0]    seq_r;
  logic [DATA_W-1:0]   data_r;
  logic [DT_W-1:0]     dt_r;
  logic [AW-1:0]       head_r, tail_r, head_inc, tail_inc;
  logic [CW-1:0]       count_r;
  logic [SEQ_W-1:0]    expected_r;
  logic [SEQ_W-1:0]    last_applied_r;
  logic [ACC_W-1:0]    accum_r, accum_nxt;
  logic [RW-1:0]       rem_r;
  logic [RW-1:0]       lim;
  logic [TW-1:0]       take_w;
  logic [RW-1:0]       take;
  logic [ACC_W:0]      accum_sum;
  logic                dup;
  logic                idle_fire;
  logic                out_free;
  logic                out_load_emit;
  logic                out_load_idle;

  logic                out_valid_r;
  logic [SEQ_W-1:0]    out_seq_r;
  logic [DATA_W-1:0]   out_payload_r;
  logic                out_idle_r;
  logic [DT_W-1:0]     out_dt_r;
  logic                out_last_r;

  assign head_inc = (head_r == AW'(QUEUE_DEPTH - 1)) ? '0 : head_r + AW'(1);
  assign tail_inc = (tail_r == AW'(QUEUE_DEPTH - 1)) ? '0 : tail_r + AW'(1);

  // drain limit clamped to 1..32
  always_comb begin
    if (drain_limit == '0) begin
      lim = RW'(1);
    end else if (RW'(drain_limit) > RW'(MAX_RESULTS)) begin
      lim = RW'(MAX_RESULTS);
    end else begin
      lim = RW'(drain_limit);
    end
  end

  assign take_w = (TW'(count_r) < TW'(lim)) ? TW'(count_r) : TW'(lim);
  assign take   = take_w[RW-1:0];

  assign dup       = seq_r < expected_r;
  assign accum_sum = {1'b0, accum_r} + (ACC_W + 1)'(dt_r);
  assign accum_nxt = accum_sum[ACC_W] ? '1 : accum_sum[ACC_W-1:0];
  assign idle_fire = accum_nxt > ACC_W'(idle_after_us);
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (op_r == OP_TICK) begin
          if (take != '0) begin
            state_nxt = S_READ;
          end else if (idle_fire) begin
            state_nxt = S_IDLE_STEP;
          end else begin
            state_nxt = S_IDLE;
          end
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_READ: begin
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          state_nxt = (rem_r == RW'(1)) ? S_IDLE : S_READ;
        end
      end
      S_IDLE_STEP: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    out_load_emit = 1'b0;
    out_load_idle = 1'b0;
    unique case (state_r)
      S_IDLE:      in_ready = 1'b1;
      S_EXEC:      mem_we = (op_r == OP_STEP) && !dup;
      S_READ:      mem_re = 1'b1;
      S_EMIT:      out_load_emit = out_free;
      S_IDLE_STEP: out_load_idle = out_free;
    endcase
  end

  assign mem_waddr = tail_r;
  assign mem_wdata = {seq_r, data_r};
  assign mem_raddr = head_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r   <= op_t'(in_opcode);
      seq_r  <= in_step_seq;
      data_r <= in_step_data;
      dt_r   <= in_tick_dt_us;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r         <= '0;
      tail_r         <= '0;
      count_r        <= '0;
      expected_r     <= '0;
      last_applied_r <= '0;
      accum_r        <= '0;
      rem_r          <= '0;
    end else begin
      if (state_r == S_EXEC) begin
        unique case (op_r)
          OP_STEP: begin
            if (!dup) begin
              expected_r <= seq_r + SEQ_W'(1);
              tail_r     <= tail_inc;
              // full: the write lands on the oldest entry
              if (count_r == CW'(QUEUE_DEPTH)) begin
                head_r <= head_inc;
              end else begin
                count_r <= count_r + CW'(1);
              end
            end
          end
          OP_TICK: begin
            if (take != '0) begin
              rem_r   <= take;
              accum_r <= '0;
            end else begin
              accum_r <= accum_nxt;
            end
          end
          OP_CLEAR: begin
            count_r <= '0;
            tail_r  <= head_r;
          end
          OP_RSVD: begin
          end
        endcase
      end
      if (out_load_emit) begin
        last_applied_r <= mem_rdata[MEM_W-1:DATA_W];
        head_r         <= head_inc;
        count_r        <= count_r - CW'(1);
        rem_r          <= rem_r - RW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load_emit || out_load_idle) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load_emit) begin
      out_seq_r     <= mem_rdata[MEM_W-1:DATA_W];
      out_payload_r <= mem_rdata[DATA_W-1:0];
      out_idle_r    <= 1'b0;
      out_dt_r      <= '0;
      out_last_r    <= rem_r == RW'(1);
    end else if (out_load_idle) begin
      out_seq_r     <= last_applied_r;
      out_payload_r <= '0;
      out_idle_r    <= 1'b1;
      out_dt_r      <= dt_r;
      out_last_r    <= 1'b1;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_seq_number  = out_seq_r;
  assign out_payload_out = out_payload_r;
  assign out_idle_step   = out_idle_r;
  assign out_idle_dt_us  = out_dt_r;
  assign out_last        = out_last_r;

  `ISQ_ASSERT_IMP(a_count_bound, 1'b1, count_r <= CW'(QUEUE_DEPTH), "queue count above depth")
  `ISQ_ASSERT_IMP(a_rw_clash, mem_we, !mem_re, "queue write and read in one cycle")
  `ISQ_ASSERT_IMP(a_drain_cover, (state_r == S_READ) || (state_r == S_EMIT), (rem_r != '0) && (TW'(rem_r) <= TW'(count_r)), "drain runs past queue contents")
  `ISQ_ASSERT_NXT(a_last_ends, out_load_emit && (rem_r == RW'(1)), state_r == S_IDLE, "tick not closed after last beat")

endmodule
